// ===== hdl/sp2a_pkg.sv =====
// Shared types, constants and helper functions of the segregated power-of-two
// block allocator. No dependencies; every other file refers to it by scope.
`default_nettype none

package sp2a_pkg;

  // Address space and size classes
  localparam int ADDR_BITS  = 20;
  localparam int MIN_LANE   = 6;
  localparam int MAX_LANE   = 16;
  localparam int LANES      = MAX_LANE - MIN_LANE + 1;
  localparam int LANE_W     = $clog2(LANES);
  localparam int SIZE_W     = ADDR_BITS + 1;
  localparam int WIDE_W     = SIZE_W + 1;
  localparam int CLS_W      = 5;
  localparam int GRAN_W     = ADDR_BITS - MIN_LANE;
  localparam int LINK_W     = GRAN_W + 1;
  localparam int LINK_DEPTH = 1 << GRAN_W;

  localparam logic [WIDE_W-1:0] SPACE = WIDE_W'(1) << ADDR_BITS;

  // Page shift register
  localparam int PS_W     = 5;
  localparam int PS_MIN   = 6;
  localparam int PS_MAX   = 20;
  localparam int PS_RESET = 12;

  // APB register file
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_PAGE_SHIFT = 1'b0;

  // Queue depths (powers of two so that the pointers wrap by themselves)
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
  localparam int RSPQ_DEPTH = 2;
  localparam int RSPQ_PW    = $clog2(RSPQ_DEPTH);

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STS_ALLOC   = 2'd0,
    STS_RELEASE = 2'd1,
    STS_OOM     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ES_IDLE,
    ES_DECODE,
    ES_CARVE,
    ES_POP,
    ES_OUT
  } eng_state_e;

  typedef struct packed {
    logic                 opcode;
    logic [SIZE_W-1:0]    size_bytes;
    logic [ADDR_BITS-1:0] block_addr;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [ADDR_BITS-1:0] granted_addr;
    logic [CLS_W-1:0]     size_class;
    logic [SIZE_W-1:0]    bytes_in_use;
    logic [SIZE_W-1:0]    peak_in_use;
  } rsp_t;

  // Classified request handed from the front end to the engine
  typedef struct packed {
    logic              is_rel;
    logic              pooled;
    logic [CLS_W-1:0]  cls;
    logic [LANE_W-1:0] lane;
    logic [GRAN_W-1:0] gran;
    logic [SIZE_W-1:0] amount;
  } cmd_t;

  // ceil(log2(size)), floored at MIN_LANE
  function automatic logic [CLS_W-1:0] size_class(input logic [SIZE_W-1:0] size);
    logic [CLS_W-1:0] msb;
    logic             pow2;
    logic [CLS_W-1:0] cls;
    msb = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (size[i]) begin
        msb = CLS_W'(i);
      end
    end
    pow2 = ((size & (size - SIZE_W'(1))) == '0);
    if (size <= (SIZE_W'(1) << MIN_LANE)) begin
      cls = CLS_W'(MIN_LANE);
    end else begin
      cls = msb + CLS_W'(!pow2);
    end
    return cls;
  endfunction

  // Page shift clamped to its legal range
  function automatic logic [PS_W-1:0] eff_shift(input logic [PS_W-1:0] ps);
    logic [PS_W-1:0] r;
    if (ps < PS_W'(PS_MIN)) begin
      r = PS_W'(PS_MIN);
    end else if (ps > PS_W'(PS_MAX)) begin
      r = PS_W'(PS_MAX);
    end else begin
      r = ps;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sp2a_front.sv =====
// Front end: classifies incoming requests and holds them in a short queue.
// Depends on sp2a_pkg.
`default_nettype none

module sp2a_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire sp2a_pkg::req_t   req_i,
  output logic                  cmd_valid_o,
  output sp2a_pkg::cmd_t        cmd_o,
  input  wire logic             cmd_pop_i
);

  sp2a_pkg::cmd_t                    cls_cmd;
  logic [sp2a_pkg::CLS_W-1:0]        cls;
  sp2a_pkg::cmd_t                    slots_q [sp2a_pkg::CMDQ_DEPTH];
  logic [sp2a_pkg::CMDQ_PW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [sp2a_pkg::CMDQ_PW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [sp2a_pkg::CMDQ_PW:0]        cnt_q, cnt_d;
  logic                              do_wr, do_rd;

  // Size class, lane and byte amount of the request
  always_comb begin
    cls            = sp2a_pkg::size_class(req_i.size_bytes);
    cls_cmd.is_rel = (req_i.opcode == sp2a_pkg::OP_RELEASE);
    cls_cmd.cls    = cls;
    cls_cmd.pooled = (cls <= sp2a_pkg::CLS_W'(sp2a_pkg::MAX_LANE));
    cls_cmd.gran   = req_i.block_addr[sp2a_pkg::ADDR_BITS-1:sp2a_pkg::MIN_LANE];
    if (cls_cmd.pooled) begin
      cls_cmd.lane   = sp2a_pkg::LANE_W'(cls - sp2a_pkg::CLS_W'(sp2a_pkg::MIN_LANE));
      cls_cmd.amount = sp2a_pkg::SIZE_W'(1) << cls;
    end else begin
      cls_cmd.lane   = '0;
      cls_cmd.amount = req_i.size_bytes;
    end
  end

  // Command queue control
  assign full        = (cnt_q == (sp2a_pkg::CMDQ_PW + 1)'(sp2a_pkg::CMDQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slots_q[rd_ptr_q];
  assign do_wr       = push && !full;
  assign do_rd       = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (sp2a_pkg::CMDQ_PW + 1)'(do_wr) - (sp2a_pkg::CMDQ_PW + 1)'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slots_q[wr_ptr_q] <= cls_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sp2a_engine.sv =====
// Back end: list heads, link memory, bump pointer, page carving and usage
// counters. Depends on sp2a_pkg.
`default_nettype none

module sp2a_engine (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [sp2a_pkg::PS_W-1:0]   page_shift_i,
  input  wire logic                        cmd_valid_i,
  input  wire sp2a_pkg::cmd_t              cmd_i,
  output logic                             cmd_pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output sp2a_pkg::rsp_t                   rsp_o
);

  localparam int GW  = sp2a_pkg::GRAN_W;
  localparam int WW  = sp2a_pkg::WIDE_W;
  localparam int SW  = sp2a_pkg::SIZE_W;
  localparam int AB  = sp2a_pkg::ADDR_BITS;
  localparam int ML  = sp2a_pkg::MIN_LANE;

  sp2a_pkg::eng_state_e      state_q, state_d;
  sp2a_pkg::cmd_t            cur_q, cur_d;

  // List heads: valid bits are reset, granule addresses are payload
  logic                      head_vld_q [sp2a_pkg::LANES];
  logic [GW-1:0]             head_g_q   [sp2a_pkg::LANES];
  logic                      head_we;
  logic                      head_wv;
  logic [GW-1:0]             head_wg;

  // Link memory
  logic [sp2a_pkg::LINK_W-1:0] link_mem [sp2a_pkg::LINK_DEPTH];
  logic                        mem_we;
  logic [GW-1:0]               mem_wa;
  logic [sp2a_pkg::LINK_W-1:0] mem_wd;
  logic [GW-1:0]               mem_ra;
  logic [sp2a_pkg::LINK_W-1:0] mem_rdata_q;

  logic [SW-1:0]             fresh_q, fresh_d;
  logic [SW-1:0]             used_q, used_d;
  logic [SW-1:0]             peak_q, peak_d;
  logic [GW:0]               carve_q, carve_d;
  logic [GW:0]               carve_end_q, carve_end_d;
  logic [GW:0]               carve_step_q, carve_step_d;
  sp2a_pkg::status_e         res_status_q, res_status_d;
  logic [AB-1:0]             res_addr_q, res_addr_d;

  logic [sp2a_pkg::PS_W-1:0] eps;
  logic [WW-1:0]             pg, pg_mask, base, kbytes, span, room, fill_end;
  logic                      fits;
  logic                      hv;
  logic [GW-1:0]             hg;
  logic [WW-1:0]             sum;
  logic [SW-1:0]             used_add, used_sub, peak_add;
  logic [GW:0]               base_g, carve_next;
  logic                      carve_more;

  // Bump pointer rounding and fit check
  always_comb begin
    eps      = sp2a_pkg::eff_shift(page_shift_i);
    pg       = WW'(1) << eps;
    pg_mask  = pg - WW'(1);
    base     = (WW'(fresh_q) + pg_mask) & ~pg_mask;
    kbytes   = WW'(1) << cur_q.cls;
    span     = (kbytes > pg) ? kbytes : pg;
    room     = sp2a_pkg::SPACE - base;
    fits     = (span <= room);
    fill_end = base + span;
    base_g   = base[AB:ML];
  end

  // Head of the current lane
  assign hv = head_vld_q[cur_q.lane];
  assign hg = head_g_q[cur_q.lane];

  // Saturating usage arithmetic
  always_comb begin
    sum      = WW'(used_q) + WW'(cur_q.amount);
    used_add = (sum > sp2a_pkg::SPACE) ? sp2a_pkg::SPACE[SW-1:0] : sum[SW-1:0];
    used_sub = (used_q > cur_q.amount) ? used_q - cur_q.amount : '0;
    peak_add = (used_add > peak_q) ? used_add : peak_q;
  end

  // Carving walk through one fresh page
  assign carve_next = carve_q + carve_step_q;
  assign carve_more = (carve_next < carve_end_q);

  // Sequencer: next state and datapath controls
  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    cmd_pop_o    = 1'b0;
    out_valid_o  = 1'b0;
    head_we      = 1'b0;
    head_wv      = 1'b0;
    head_wg      = '0;
    mem_we       = 1'b0;
    mem_wa       = '0;
    mem_wd       = '0;
    mem_ra       = hg;
    fresh_d      = fresh_q;
    used_d       = used_q;
    peak_d       = peak_q;
    carve_d      = carve_q;
    carve_end_d  = carve_end_q;
    carve_step_d = carve_step_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    case (state_q)
      sp2a_pkg::ES_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          state_d   = sp2a_pkg::ES_DECODE;
        end
      end
      sp2a_pkg::ES_DECODE: begin
        if (cur_q.is_rel) begin
          // Release: push pooled blocks, always lower the count
          res_status_d = sp2a_pkg::STS_RELEASE;
          res_addr_d   = '0;
          used_d       = used_sub;
          if (cur_q.pooled) begin
            mem_we  = 1'b1;
            mem_wa  = cur_q.gran;
            mem_wd  = {hv, hg};
            head_we = 1'b1;
            head_wv = 1'b1;
            head_wg = cur_q.gran;
          end
          state_d = sp2a_pkg::ES_OUT;
        end else if (!cur_q.pooled) begin
          // Large block straight from the bump pointer
          if (fits) begin
            fresh_d      = fill_end[SW-1:0];
            res_status_d = sp2a_pkg::STS_ALLOC;
            res_addr_d   = base[AB-1:0];
            used_d       = used_add;
            peak_d       = peak_add;
          end else begin
            res_status_d = sp2a_pkg::STS_OOM;
            res_addr_d   = '0;
          end
          state_d = sp2a_pkg::ES_OUT;
        end else if (hv) begin
          // Head read issued, link arrives next cycle
          state_d = sp2a_pkg::ES_POP;
        end else if (!fits) begin
          res_status_d = sp2a_pkg::STS_OOM;
          res_addr_d   = '0;
          state_d      = sp2a_pkg::ES_OUT;
        end else begin
          // Refill the empty list
          fresh_d = fill_end[SW-1:0];
          head_we = 1'b1;
          head_wv = 1'b1;
          head_wg = base_g[GW-1:0];
          if (kbytes < pg) begin
            carve_d      = base_g;
            carve_end_d  = base_g + pg[AB:ML];
            carve_step_d = kbytes[AB:ML];
            state_d      = sp2a_pkg::ES_CARVE;
          end else begin
            mem_we = 1'b1;
            mem_wa = base_g[GW-1:0];
            mem_wd = '0;
          end
        end
      end
      sp2a_pkg::ES_CARVE: begin
        mem_we  = 1'b1;
        mem_wa  = carve_q[GW-1:0];
        mem_wd  = carve_more ? {1'b1, carve_next[GW-1:0]} : '0;
        carve_d = carve_next;
        if (!carve_more) begin
          state_d = sp2a_pkg::ES_DECODE;
        end
      end
      sp2a_pkg::ES_POP: begin
        head_we      = 1'b1;
        head_wv      = mem_rdata_q[GW];
        head_wg      = mem_rdata_q[GW-1:0];
        res_status_d = sp2a_pkg::STS_ALLOC;
        res_addr_d   = {hg, {ML{1'b0}}};
        used_d       = used_add;
        peak_d       = peak_add;
        state_d      = sp2a_pkg::ES_OUT;
      end
      sp2a_pkg::ES_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = sp2a_pkg::ES_IDLE;
        end
      end
      default: begin
        state_d = sp2a_pkg::ES_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sp2a_pkg::ES_IDLE;
      fresh_q <= '0;
      used_q  <= '0;
      peak_q  <= '0;
      for (int i = 0; i < sp2a_pkg::LANES; i++) begin
        head_vld_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      fresh_q <= fresh_d;
      used_q  <= used_d;
      peak_q  <= peak_d;
      if (head_we) begin
        head_vld_q[cur_q.lane] <= head_wv;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    carve_q      <= carve_d;
    carve_end_q  <= carve_end_d;
    carve_step_q <= carve_step_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    if (head_we) begin
      head_g_q[cur_q.lane] <= head_wg;
    end
  end

  // Link memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    mem_rdata_q <= link_mem[mem_ra];
  end

  // Result fields
  always_comb begin
    rsp_o.status       = res_status_q;
    rsp_o.granted_addr = res_addr_q;
    rsp_o.size_class   = cur_q.cls;
    rsp_o.bytes_in_use = used_q;
    rsp_o.peak_in_use  = peak_q;
  end

`ifndef ASSERT_OFF
  a_peak_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (peak_q >= used_q) && (WW'(peak_q) <= sp2a_pkg::SPACE))
    else $error("peak below used count or above address space");

  a_fresh_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(fresh_q) <= sp2a_pkg::SPACE)
    else $error("bump pointer beyond address space");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sp2a_pkg::ES_POP) |-> head_vld_q[cur_q.lane])
    else $error("pop from an empty list");

  a_carve_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sp2a_pkg::ES_CARVE) |-> (cur_q.pooled && !cur_q.is_rel))
    else $error("carving outside a pooled allocation");
`endif

endmodule

`default_nettype wire

// ===== hdl/sp2a_res_queue.sv =====
// Result queue between the engine and the output ports.
// Depends on sp2a_pkg.
`default_nettype none

module sp2a_res_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire sp2a_pkg::rsp_t  in_rsp_i,
  output logic                 empty,
  input  wire logic            pop,
  output sp2a_pkg::rsp_t       rsp_o
);

  sp2a_pkg::rsp_t                slots_q [sp2a_pkg::RSPQ_DEPTH];
  logic [sp2a_pkg::RSPQ_PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [sp2a_pkg::RSPQ_PW:0]    cnt_q, cnt_d;
  logic                          do_wr, do_rd;

  assign in_ready_o = (cnt_q != (sp2a_pkg::RSPQ_PW + 1)'(sp2a_pkg::RSPQ_DEPTH));
  assign empty      = (cnt_q == '0);
  assign rsp_o      = slots_q[rd_ptr_q];
  assign do_wr      = in_valid_i && in_ready_o;
  assign do_rd      = pop && !empty;

  always_comb begin
    cnt_d = cnt_q + (sp2a_pkg::RSPQ_PW + 1)'(do_wr) - (sp2a_pkg::RSPQ_PW + 1)'(do_rd);
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slots_q[wr_ptr_q] <= in_rsp_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/segregated_pow2_block_allocator_top.sv =====
// A release, a large or an out-of-memory request goes from idle through decode to out;
// a pooled allocation from a non-empty list also passes pop. No new request is taken
// until the last result is handed to the result queue; out waits while that queue is
// full. Refilling an empty list runs decode again before pop, with carving in between,
// one link memory write per block, when the class is below the page.
// Reset: asynchronous, all lists empty, counters zero, page_shift 12; the link memory
// needs no clearing pass. Uses sp2a_pkg, sp2a_front, sp2a_engine, sp2a_res_queue.
`default_nettype none

module segregated_pow2_block_allocator_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire sp2a_pkg::req_t                req_i,
  output logic                               empty,
  input  wire logic                          pop,
  output sp2a_pkg::rsp_t                     rsp_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sp2a_pkg::APB_AW-1:0]   paddr,
  input  wire logic [sp2a_pkg::APB_DW-1:0]   pwdata,
  output logic [sp2a_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);

  logic [sp2a_pkg::PS_W-1:0] page_shift_q;
  logic                      cfg_wr;
  logic                      cmd_valid, cmd_pop;
  sp2a_pkg::cmd_t            cmd;
  logic                      eng_valid, eng_ready;
  sp2a_pkg::rsp_t            eng_rsp;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[sp2a_pkg::APB_AW-1] == sp2a_pkg::REG_PAGE_SHIFT);
  assign prdata = (paddr[sp2a_pkg::APB_AW-1] == sp2a_pkg::REG_PAGE_SHIFT)
                  ? sp2a_pkg::APB_DW'(page_shift_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q <= sp2a_pkg::PS_W'(sp2a_pkg::PS_RESET);
    end else if (cfg_wr) begin
      page_shift_q <= pwdata[sp2a_pkg::PS_W-1:0];
    end
  end

  sp2a_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  sp2a_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .page_shift_i (page_shift_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .out_valid_o  (eng_valid),
    .out_ready_i  (eng_ready),
    .rsp_o        (eng_rsp)
  );

  sp2a_res_queue u_res_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (eng_valid),
    .in_ready_o (eng_ready),
    .in_rsp_i   (eng_rsp),
    .empty      (empty),
    .pop        (pop),
    .rsp_o      (rsp_o)
  );

endmodule

`default_nettype wire
